// ----- rtl/ccc_pkg.sv -----
// ----------------------------------------------------------------------------
// ccc_pkg
// Shared constants and types of the costmap disc clearance check.
// ----------------------------------------------------------------------------
package ccc_pkg;

    localparam int MAP_WIDTH        = 256;
    localparam int MAP_HEIGHT       = 256;
    localparam int MAX_SEARCH_CELLS = 8;

    localparam int GRID_DEPTH = 65536;
    localparam int GRID_AW    = $clog2(GRID_DEPTH);
    localparam int COST_W     = 8;

    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CS_W       = 21;
    localparam int CR_W       = 23;
    localparam int TRIG_W     = 16;
    localparam int POS_W      = 32;

    localparam int DIFF_W     = POS_W + 1;
    localparam int PROD_W     = DIFF_W + TRIG_W;
    localparam int ACC_W      = PROD_W + 1;
    localparam int FRAC_SH    = 14;
    localparam int LX_W       = 36;
    localparam int EW         = LX_W + 3;
    localparam int RAD_W      = 25;
    localparam int SQ_W       = 2 * RAD_W;

    localparam int MAP_DIM_MAX = (MAP_WIDTH > MAP_HEIGHT) ? MAP_WIDTH : MAP_HEIGHT;
    localparam int COORD_W     = $clog2(MAP_DIM_MAX + MAX_SEARCH_CELLS + 1) + 1;
    localparam int CNT_W       = $clog2(2 * MAX_SEARCH_CELLS + 2);

    localparam int DIV_W      = LX_W;

    localparam logic [16:0] SQRT2_Q16 = 17'd92682;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_COS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_SIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEARANCE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_COST  = 3'd6;

    localparam logic REQ_WRITE = 1'b0;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [CS_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
    } t_div_rsp;

endpackage

// ----- rtl/ccc_ram.sv -----
// ----------------------------------------------------------------------------
// ccc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ccc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/ccc_div.sv -----
// ----------------------------------------------------------------------------
// ccc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ccc_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ccc_pkg::t_div_req i_req,
    output ccc_pkg::t_div_rsp o_rsp
);
    import ccc_pkg::*;

    localparam int CNT_DW = $clog2(DIV_W + 1);

    logic [DIV_W-1:0]  r_q;
    logic [CS_W:0]     r_rem;
    logic [CS_W-1:0]   r_den;
    logic [CNT_DW-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [CS_W+1:0]   shifted;
    logic              fits;
    logic [CS_W+1:0]   diff;

    always_comb begin
        shifted = {r_rem, r_q[DIV_W-1]};
        diff    = shifted - {2'b00, r_den};
        fits    = shifted >= {2'b00, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_DW'(DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_DW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend;
            r_den <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? diff[CS_W:0] : shifted[CS_W:0];
            r_q   <= {r_q[DIV_W-2:0], fits};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

endmodule

// ----- rtl/costmap_disc_clearance_check.sv -----
// ----------------------------------------------------------------------------
// costmap_disc_clearance_check
// Cost grid store and clearance disc check of a goal point.
// ----------------------------------------------------------------------------
//  channel  direction  handshake               payload
//  in       input      i_in_valid / o_in_stall  req_type cell_index cell_cost goal_x goal_y
//  out      output     o_out_valid / i_out_stall is_safe
//  cfg      input      i_cfg_we                 cfg_idx cfg_data
//
//  a cell write is accepted in S_IDLE; the time of a query is set by the serial divider
//  (three divisions) and one grid read per cell of the (2s+1)^2 window, s the window
//  half-width; a query refused at the range check skips the divider and the scan
//  no clearing pass after reset; the grid content is undefined until written
//  a result waiting on i_out_stall does not block the next word; a finished query
//  holds until the output register is free
// ----------------------------------------------------------------------------
module costmap_disc_clearance_check (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_req_type,
    input  logic [15:0]                       i_cell_index,
    input  logic [7:0]                        i_cell_cost,
    input  logic signed [31:0]                i_goal_x,
    input  logic signed [31:0]                i_goal_y,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_is_safe,
    input  logic                              i_cfg_we,
    input  logic [ccc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ccc_pkg::CFG_W-1:0]         i_cfg_data
);
    import ccc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DIFF, S_MUL0, S_MUL1, S_MUL2, S_MUL3, S_MUL4, S_CHK,
        S_DIVX, S_DIVY, S_DIVS, S_SETUP, S_SCAN, S_DRAIN, S_DONE
    } t_state;

    t_state r_state;

    logic signed [POS_W-1:0]  r_origin_x, r_origin_y;
    logic signed [TRIG_W-1:0] r_cos, r_sin;
    logic [CS_W-1:0]          r_cs;
    logic [CR_W-1:0]          r_cr;
    logic [COST_W-1:0]        r_max_cost;

    logic signed [POS_W-1:0]  r_gx, r_gy;
    logic signed [DIFF_W-1:0] r_dx, r_dy;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_lx30, r_ly30;
    logic [LX_W-1:0]          r_lx, r_ly;
    logic [RAD_W-1:0]         r_rad;
    logic [SQ_W-1:0]          r_r2;
    logic signed [COORD_W-1:0] r_cx, r_cy, r_x0, r_x, r_y;
    logic [CNT_W-1:0]         r_span, r_ix, r_iy;
    logic signed [EW-1:0]     r_ex0, r_ex, r_ey;
    logic                     r_safe;
    logic                     r_out_vld;
    logic                     r_is_safe;

    logic                     r_a_vld, r_a_big, r_a_out;
    logic [SQ_W-1:0]          r_a_ex2, r_a_ey2;

    t_div_req                 r_div_req;
    t_div_rsp                 div_rsp;

    logic                     in_acc;
    logic signed [TRIG_W-1:0] mul_a;
    logic signed [DIFF_W-1:0] mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic [LX_W-1:0]          lx_trunc, ly_trunc;
    logic [LX_W-1:0]          lim_x, lim_y;
    logic                     chk_fail;
    logic                     div_go;
    logic [41:0]              rad_sum;
    logic [DIV_W-1:0]         s_plus;
    logic signed [EW-1:0]     ex_abs, ey_abs;
    logic                     ex_big, ey_big, cell_out;
    logic [31:0]              addr_full;
    logic [GRID_AW-1:0]       rd_addr;
    logic [COST_W-1:0]        rd_cost;
    logic [SQ_W:0]            dist2;
    logic                     a_fail;
    logic signed [EW-1:0]     ex_init, ey_init;
    logic signed [EW-1:0]     step2;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);

    ccc_ram #(.WIDTH(COST_W), .DEPTH(GRID_DEPTH)) u_grid (
        .i_clk   (i_clk),
        .i_we    (in_acc && (i_req_type == REQ_WRITE)),
        .i_waddr (i_cell_index[GRID_AW-1:0]),
        .i_wdata (i_cell_cost),
        .i_raddr (rd_addr),
        .o_rdata (rd_cost)
    );

    ccc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        case (r_state)
            S_MUL0:  begin mul_a = r_cos; mul_b = r_dx; end
            S_MUL1:  begin mul_a = r_sin; mul_b = r_dy; end
            S_MUL2:  begin mul_a = r_cos; mul_b = r_dy; end
            default: begin mul_a = r_sin; mul_b = r_dx; end
        endcase
        mul_p = mul_a * mul_b;

        lx_trunc = r_lx30[LX_W+FRAC_SH-1:FRAC_SH];
        ly_trunc = r_ly30[LX_W+FRAC_SH-1:FRAC_SH];
        lim_x    = LX_W'(r_cs) * LX_W'(MAP_WIDTH);
        lim_y    = LX_W'(r_cs) * LX_W'(MAP_HEIGHT);
        chk_fail = (r_lx30 < 0) || (r_ly30 < 0) || (lx_trunc >= lim_x)
                   || (ly_trunc >= lim_y);
        div_go   = ((r_state == S_CHK) && !chk_fail)
                   || (((r_state == S_DIVX) || (r_state == S_DIVY)) && div_rsp.done);
        rad_sum  = {2'b00, r_cr, 17'd0} + 42'(r_cs) * 42'(SQRT2_Q16) + 42'd32768;
        s_plus   = div_rsp.quot + 1'b1;

        ex_init = EW'($signed({r_x0, 1'b1}) * $signed({1'b0, r_cs}))
                  - $signed({2'b00, r_lx, 1'b0});
        ey_init = EW'($signed({r_y, 1'b1}) * $signed({1'b0, r_cs}))
                  - $signed({2'b00, r_ly, 1'b0});
        step2   = $signed({{(EW-CS_W-1){1'b0}}, r_cs, 1'b0});

        ex_abs = r_ex[EW-1] ? -r_ex : r_ex;
        ey_abs = r_ey[EW-1] ? -r_ey : r_ey;
        ex_big = |ex_abs[EW-1:RAD_W];
        ey_big = |ey_abs[EW-1:RAD_W];
        cell_out = (r_x < 0) || (r_y < 0)
                   || (r_x >= $signed(COORD_W'(MAP_WIDTH)))
                   || (r_y >= $signed(COORD_W'(MAP_HEIGHT)));
        addr_full = {{(32-COORD_W){r_y[COORD_W-1]}}, r_y} * 32'(MAP_WIDTH)
                    + {{(32-COORD_W){r_x[COORD_W-1]}}, r_x};
        rd_addr = addr_full[GRID_AW-1:0];

        dist2  = {1'b0, r_a_ex2} + {1'b0, r_a_ey2};
        a_fail = r_a_vld && !r_a_big && (dist2 <= {1'b0, r_r2})
                 && (r_a_out || (rd_cost > r_max_cost));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_cos      <= 16'sd16384;
            r_sin      <= '0;
            r_cs       <= 21'd3277;
            r_cr       <= 23'd32768;
            r_max_cost <= 8'd252;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ORIGIN_X:  r_origin_x <= i_cfg_data;
                CFG_ORIGIN_Y:  r_origin_y <= i_cfg_data;
                CFG_MAP_COS:   r_cos      <= i_cfg_data[TRIG_W-1:0];
                CFG_MAP_SIN:   r_sin      <= i_cfg_data[TRIG_W-1:0];
                CFG_CELL_SIZE: r_cs       <= i_cfg_data[CS_W-1:0];
                CFG_CLEARANCE: r_cr       <= i_cfg_data[CR_W-1:0];
                CFG_MAX_COST:  r_max_cost <= i_cfg_data[COST_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_out_vld       <= 1'b0;
            r_a_vld         <= 1'b0;
            r_div_req.start <= 1'b0;
        end else begin
            r_div_req.start <= div_go;
            r_a_vld         <= (r_state == S_SCAN);
            if (r_out_vld && !i_out_stall && (r_state != S_DONE)) begin
                r_out_vld <= 1'b0;
            end
            if (a_fail) begin
                r_safe <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc && (i_req_type != REQ_WRITE)) begin
                        r_gx    <= i_goal_x;
                        r_gy    <= i_goal_y;
                        r_state <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    r_dx    <= DIFF_W'(r_gx) - DIFF_W'(r_origin_x);
                    r_dy    <= DIFF_W'(r_gy) - DIFF_W'(r_origin_y);
                    r_state <= S_MUL0;
                end
                S_MUL0: begin
                    r_prod  <= mul_p;
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_lx30  <= ACC_W'(r_prod);
                    r_prod  <= mul_p;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_lx30  <= r_lx30 + ACC_W'(r_prod);
                    r_prod  <= mul_p;
                    r_state <= S_MUL3;
                end
                S_MUL3: begin
                    r_ly30  <= ACC_W'(r_prod);
                    r_prod  <= mul_p;
                    r_state <= S_MUL4;
                end
                S_MUL4: begin
                    r_ly30  <= r_ly30 - ACC_W'(r_prod);
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    r_lx  <= lx_trunc;
                    r_ly  <= ly_trunc;
                    r_rad <= rad_sum[RAD_W+15:16];
                    if (chk_fail) begin
                        r_safe  <= 1'b0;
                        r_state <= S_DONE;
                    end else begin
                        r_safe             <= 1'b1;
                        r_div_req.dividend <= lx_trunc;
                        r_div_req.divisor  <= r_cs;
                        r_state            <= S_DIVX;
                    end
                end
                S_DIVX: begin
                    r_r2 <= r_rad * r_rad;
                    if (div_rsp.done) begin
                        r_cx               <= COORD_W'(div_rsp.quot);
                        r_div_req.dividend <= r_ly;
                        r_state            <= S_DIVY;
                    end
                end
                S_DIVY: begin
                    if (div_rsp.done) begin
                        r_cy               <= COORD_W'(div_rsp.quot);
                        r_div_req.dividend <= DIV_W'(r_cr) + DIV_W'(r_cs) - 1'b1;
                        r_state            <= S_DIVS;
                    end
                end
                S_DIVS: begin
                    if (div_rsp.done) begin
                        if (s_plus > DIV_W'(MAX_SEARCH_CELLS)) begin
                            r_safe  <= 1'b0;
                            r_state <= S_DONE;
                        end else begin
                            r_x0    <= r_cx - COORD_W'(s_plus);
                            r_y     <= r_cy - COORD_W'(s_plus);
                            r_span  <= CNT_W'({s_plus, 1'b0});
                            r_state <= S_SETUP;
                        end
                    end
                end
                S_SETUP: begin
                    r_ex0   <= ex_init;
                    r_ex    <= ex_init;
                    r_ey    <= ey_init;
                    r_x     <= r_x0;
                    r_ix    <= '0;
                    r_iy    <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    r_a_big <= ex_big || ey_big;
                    r_a_out <= cell_out;
                    r_a_ex2 <= ex_abs[RAD_W-1:0] * ex_abs[RAD_W-1:0];
                    r_a_ey2 <= ey_abs[RAD_W-1:0] * ey_abs[RAD_W-1:0];
                    if (r_ix == r_span) begin
                        r_ix <= '0;
                        r_x  <= r_x0;
                        r_ex <= r_ex0;
                        r_iy <= r_iy + 1'b1;
                        r_y  <= r_y + 1'b1;
                        r_ey <= r_ey + step2;
                        if (r_iy == r_span) begin
                            r_state <= S_DRAIN;
                        end
                    end else begin
                        r_ix <= r_ix + 1'b1;
                        r_x  <= r_x + 1'b1;
                        r_ex <= r_ex + step2;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_vld || !i_out_stall) begin
                        r_out_vld <= 1'b1;
                        r_is_safe <= r_safe;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_is_safe   = r_is_safe;

endmodule
